// ===== hw/rtl/ucsa_pkg.sv =====
// Package of shared types, constants and functions for the UID cascade select assembler.
`default_nettype none

package ucsa_pkg;

   localparam int UID_BYTES_DEF  = 10;
   localparam int LEVELS_DEF     = 3;
   localparam int UID_BYTES_OUT  = 10;
   localparam int LEN_W          = 4;

   localparam logic [7:0]  CASCADE_TAG   = 8'h88;
   localparam logic [7:0]  SEL_CODE_CL1  = 8'h93;
   localparam logic [7:0]  SEL_CODE_CL2  = 8'h95;
   localparam logic [7:0]  SEL_CODE_CL3  = 8'h97;
   localparam int          SAK_MORE_BIT  = 2;
   localparam logic [15:0] CRCA_PRESET   = 16'h6363;
   localparam logic [15:0] CRCA_POLY     = 16'h8408;

   typedef enum logic [3:0] {
      ST_CONTINUE      = 4'd0,
      ST_COMPLETE      = 4'd1,
      ST_ANTICOLL_FAIL = 4'd2,
      ST_BCC_FAIL      = 4'd3,
      ST_SELECT_FAIL   = 4'd4,
      ST_CRC_FAIL      = 4'd5,
      ST_TOO_LONG      = 4'd6,
      ST_NO_TAG        = 4'd7,
      ST_LEVELS        = 4'd8,
      ST_BAD_LENGTH    = 4'd9
   } status_type;

   typedef struct packed {
      logic       anticoll_ok;
      logic [7:0] anticoll_byte0;
      logic [7:0] anticoll_byte1;
      logic [7:0] anticoll_byte2;
      logic [7:0] anticoll_byte3;
      logic [7:0] check_byte;
      logic       select_ok;
      logic [7:0] select_ack;
      logic [7:0] ack_crc_low;
      logic [7:0] ack_crc_high;
   } req_type;

   typedef struct packed {
      status_type       status;
      logic [7:0]       next_select_code;
      logic [LEN_W-1:0] uid_length;
      logic [7:0]       final_ack;
      logic [63:0]      uid_low;
      logic [15:0]      uid_high;
      logic             card_selected;
   } rsp_type;

   // CRC_A over a single byte, reflected, low bit first
   function automatic logic [15:0] crca_byte(input logic [7:0] data);
      logic [15:0] crc;
      crc = CRCA_PRESET ^ {8'h00, data};
      for (int i = 0; i < 8; i++) begin
         if (crc[0]) begin
            crc = (crc >> 1) ^ CRCA_POLY;
         end else begin
            crc = crc >> 1;
         end
      end
      return crc;
   endfunction

   function automatic logic [7:0] sel_code(input logic [1:0] level);
      logic [7:0] code;
      case (level)
         2'd1:    code = SEL_CODE_CL2;
         2'd2:    code = SEL_CODE_CL3;
         default: code = SEL_CODE_CL1;
      endcase
      return code;
   endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/ucsa_chan_if.sv =====
// Valid/ready channel interface carrying one payload struct.
`default_nettype none

interface ucsa_chan_if #(
   parameter type payload_type = logic
);
   logic        valid;
   logic        ready;
   payload_type payload;

   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

`default_nettype wire

// ===== hw/rtl/uid_cascade_select_assembler.sv =====
// Top level: assembles a card UID across cascade levels from per-level exchange outcomes.
`default_nettype none

// Usage
//   req_chan (sink) carries one request per cascade level: the anticollision
//   outcome (four bytes plus BCC) and the select outcome (SAK plus CRC_A).
//   rsp_chan (source) returns exactly one response per request: status, the
//   select code for the next level, the UID bytes held and the SAK.
//   Both channels move a request or response when valid and ready are high
//   at a rising clock edge.
// Timing
//   A request is registered, evaluated and its response registered. One
//   request per cycle is sustained while rsp_chan.ready is high; the rate
//   is set by the single evaluation stage between input and output
//   registers, which also updates the level, length and UID store.
// Reset
//   Synchronous, active high: both stages empty, level and length zero, UID
//   store all zero. Any terminal status returns level, length and UID store to the same values.
// Stall
//   While rsp_chan.ready is low the response holds; one further request may
//   wait in the input register, then req_chan.ready drops.

module uid_cascade_select_assembler #(
   parameter int MAX_UID_BYTES = ucsa_pkg::UID_BYTES_DEF,
   parameter int MAX_LEVELS    = ucsa_pkg::LEVELS_DEF
) (
   input  wire logic  clock,
   input  wire logic  reset,
   ucsa_chan_if.sink   req_chan,
   ucsa_chan_if.source rsp_chan
);
   import ucsa_pkg::*;

   localparam logic [LEN_W:0] LenLimit   = (LEN_W+1)'(MAX_UID_BYTES);
   localparam logic [2:0]     LevelLimit = 3'(MAX_LEVELS);

   // pipeline registers
   logic       in_valid_ff;
   req_type    in_ff;
   logic       out_valid_ff;
   rsp_type    out_ff;

   // assembly state
   logic [1:0]       level_ff, level_in;
   logic [LEN_W-1:0] length_ff, length_in;
   logic [7:0]       uid_ff [MAX_UID_BYTES];
   logic [7:0]       uid_in [MAX_UID_BYTES];

   logic             advance;
   logic             out_free;
   rsp_type          rsp_in;

   logic [7:0]       rx_byte [4];
   logic             bcc_ok;
   logic             crc_ok;
   logic [15:0]      crc_calc;
   logic             tag;
   logic [2:0]       byte_cnt;
   logic [LEN_W:0]   len_sum;
   logic [7:0]       uid_app [MAX_UID_BYTES];
   logic [7:0]       uid_view [MAX_UID_BYTES];
   logic [8*UID_BYTES_OUT-1:0] uid_flat;
   status_type       status;
   logic             early_fail;
   logic [1:0]       level_next;

   // handshake: output register frees when taken, input stage advances into it
   assign out_free         = !out_valid_ff || rsp_chan.ready;
   assign advance          = in_valid_ff && out_free;
   assign req_chan.ready   = !in_valid_ff || advance;
   assign rsp_chan.valid   = out_valid_ff;
   assign rsp_chan.payload = out_ff;

   assign rx_byte[0] = in_ff.anticoll_byte0;
   assign rx_byte[1] = in_ff.anticoll_byte1;
   assign rx_byte[2] = in_ff.anticoll_byte2;
   assign rx_byte[3] = in_ff.anticoll_byte3;

   assign bcc_ok   = (rx_byte[0] ^ rx_byte[1] ^ rx_byte[2] ^ rx_byte[3]) == in_ff.check_byte;
   assign crc_calc = crca_byte(in_ff.select_ack);
   assign crc_ok   = (crc_calc[7:0] == in_ff.ack_crc_low) && (crc_calc[15:8] == in_ff.ack_crc_high);

   // a leading cascade tag is stripped, leaving three UID bytes
   assign tag        = rx_byte[0] == CASCADE_TAG;
   assign byte_cnt   = tag ? 3'd3 : 3'd4;
   assign len_sum    = {1'b0, length_ff} + {{(LEN_W-2){1'b0}}, byte_cnt};
   assign level_next = level_ff + 2'd1;

   // append the new bytes behind those already held
   always_comb begin
      logic [LEN_W-1:0] rel;
      for (int j = 0; j < MAX_UID_BYTES; j++) begin
         rel = LEN_W'(j) - length_ff;
         if ((LEN_W'(j) >= length_ff) && ((LEN_W+1)'(j) < len_sum)) begin
            uid_app[j] = rx_byte[rel[1:0] + {1'b0, tag}];
         end else begin
            uid_app[j] = uid_ff[j];
         end
      end
   end

   // outcome, checked in priority order
   always_comb begin
      if (!in_ff.anticoll_ok) begin
         status = ST_ANTICOLL_FAIL;
      end else if (!bcc_ok) begin
         status = ST_BCC_FAIL;
      end else if (!in_ff.select_ok) begin
         status = ST_SELECT_FAIL;
      end else if (!crc_ok) begin
         status = ST_CRC_FAIL;
      end else if (len_sum > LenLimit) begin
         status = ST_TOO_LONG;
      end else if (!in_ff.select_ack[SAK_MORE_BIT]) begin
         if (len_sum[LEN_W-1:0] inside {4'd4, 4'd7, 4'd10}) begin
            status = ST_COMPLETE;
         end else begin
            status = ST_BAD_LENGTH;
         end
      end else if (!tag) begin
         status = ST_NO_TAG;
      end else if ({1'b0, level_next} >= LevelLimit) begin
         status = ST_LEVELS;
      end else begin
         status = ST_CONTINUE;
      end
   end

   assign early_fail = (status == ST_ANTICOLL_FAIL) || (status == ST_BCC_FAIL) ||
                       (status == ST_SELECT_FAIL) || (status == ST_CRC_FAIL) ||
                       (status == ST_TOO_LONG);

   // nothing is appended on an early failure
   always_comb begin
      for (int j = 0; j < MAX_UID_BYTES; j++) begin
         uid_view[j] = early_fail ? uid_ff[j] : uid_app[j];
      end
   end

   // pad bytes beyond the store with zero
   for (genvar g = 0; g < UID_BYTES_OUT; g++) begin : g_uid_pack
      if (g < MAX_UID_BYTES) begin : g_held
         assign uid_flat[8*g +: 8] = uid_view[g];
      end else begin : g_pad
         assign uid_flat[8*g +: 8] = 8'h00;
      end
   end

   always_comb begin
      rsp_in.status           = status;
      rsp_in.next_select_code = (status == ST_CONTINUE) ? sel_code(level_next)
                                                         : sel_code(2'd0);
      rsp_in.uid_length       = early_fail ? length_ff : len_sum[LEN_W-1:0];
      rsp_in.final_ack        = early_fail ? 8'h00 : in_ff.select_ack;
      rsp_in.uid_low          = uid_flat[63:0];
      rsp_in.uid_high         = uid_flat[79:64];
      rsp_in.card_selected    = status == ST_COMPLETE;
   end

   // state update: advance on continue, clear on any terminal outcome
   always_comb begin
      level_in  = level_ff;
      length_in = length_ff;
      for (int j = 0; j < MAX_UID_BYTES; j++) begin
         uid_in[j] = uid_ff[j];
      end
      if (advance) begin
         if (status == ST_CONTINUE) begin
            level_in  = level_next;
            length_in = len_sum[LEN_W-1:0];
            for (int j = 0; j < MAX_UID_BYTES; j++) begin
               uid_in[j] = uid_app[j];
            end
         end else begin
            level_in  = 2'd0;
            length_in = '0;
            for (int j = 0; j < MAX_UID_BYTES; j++) begin
               uid_in[j] = 8'h00;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
         level_ff     <= 2'd0;
         length_ff    <= '0;
         for (int j = 0; j < MAX_UID_BYTES; j++) begin
            uid_ff[j] <= 8'h00;
         end
      end else begin
         if (req_chan.ready) begin
            in_valid_ff <= req_chan.valid;
         end
         if (out_free) begin
            out_valid_ff <= advance;
         end
         level_ff  <= level_in;
         length_ff <= length_in;
         for (int j = 0; j < MAX_UID_BYTES; j++) begin
            uid_ff[j] <= uid_in[j];
         end
      end
   end

   // payload registers: hold while stalled
   always_ff @(posedge clock) begin
      if (req_chan.valid && req_chan.ready) begin
         in_ff <= req_chan.payload;
      end
      if (advance) begin
         out_ff <= rsp_in;
      end
   end

endmodule

`default_nettype wire
